FILE: rtl/rli_pkg.sv
// Shared types and codes for the ranked list core.
// Holds command, status and sequencer state encodings; no dependencies.
package rli_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_PRINT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_FIN,
    ST_INS,
    ST_DN,
    ST_DN_FIN,
    ST_GET_RD,
    ST_GET_OUT,
    ST_PR_RD,
    ST_PR_OUT,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/ranked_list_insert_delete_core.sv
// Ranked list core: byte elements kept in list order and addressed by 1-based rank.
// Uses rli_pkg for command, status and state codes; holds the element memory itself.
//
// The core takes one request at a time and holds in_tready low until that request is
// finished. A get or a rejected request may also wait on the result channel. An add at
// rank r that does not append at the end, and a delete of any element but the last,
// move the elements behind the rank one entry a cycle through the single read and write
// port of the element memory. A print reads one element a cycle from the same read port
// while results are taken at once. The finished result sits in an output register, so
// the next request can be taken while it waits. No clearing pass is needed after reset.
module ranked_list_insert_delete_core
  import rli_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rank, [15:8] elem
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] value
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = ((CW > 8) ? CW : 8) + 1;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic [7:0]    elem_r, elem_nxt;
  status_t       resp_r, resp_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [7:0]    out_value_r, out_value_nxt;
  logic          out_last_r, out_last_nxt;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [KW-1:0] rank_ext, count_ext, rank_m1;
  logic [CW-1:0] count_m1;
  logic          add_ok, rd_ok, full, out_free, pr_last;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  assign rank_ext  = KW'(in_tdata[7:0]);
  assign count_ext = KW'(count_r);
  assign rank_m1   = rank_ext - KW'(1);
  assign count_m1  = count_r - CW'(1);
  assign add_ok    = (in_tdata[7:0] != 8'd0) && (rank_ext <= count_ext + KW'(1));
  assign rd_ok     = (in_tdata[7:0] != 8'd0) && (rank_ext <= count_ext);
  assign full      = (count_r == CW'(CAPACITY));
  assign out_free  = !out_valid_r || out_tready;
  assign pr_last   = (CW'(ptr_r) == count_m1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    wr_pend_nxt    = wr_pend_r;
    ptr_nxt        = ptr_r;
    wr_addr_nxt    = wr_addr_r;
    ridx_nxt       = ridx_r;
    elem_nxt       = elem_r;
    resp_nxt       = resp_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_addr_r;
    mem_wdata      = rd_data_r;
    mem_raddr      = ptr_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        wr_pend_nxt = 1'b0;
        if (in_tvalid) begin
          elem_nxt = in_tdata[15:8];
          ridx_nxt = rank_m1[AW-1:0];
          unique case (cmd_t'(in_tuser))
            CMD_ADD: begin
              if (!add_ok) begin
                resp_nxt  = STS_INVALID;
                state_nxt = ST_RESP;
              end else if (full) begin
                resp_nxt  = STS_FULL;
                state_nxt = ST_RESP;
              end else if (rank_m1 == count_ext) begin
                state_nxt = ST_INS;
              end else begin
                ptr_nxt   = count_m1[AW-1:0];
                state_nxt = ST_UP;
              end
            end
            CMD_DELETE: begin
              if (!rd_ok) begin
                resp_nxt  = STS_INVALID;
                state_nxt = ST_RESP;
              end else if (rank_ext == count_ext) begin
                state_nxt = ST_DN_FIN;
              end else begin
                ptr_nxt   = rank_ext[AW-1:0];
                state_nxt = ST_DN;
              end
            end
            CMD_GET: begin
              if (!rd_ok) begin
                resp_nxt  = STS_INVALID;
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_GET_RD;
              end
            end
            CMD_PRINT: begin
              if (count_r == CW'(0)) begin
                resp_nxt  = STS_INVALID;
                state_nxt = ST_RESP;
              end else begin
                ptr_nxt   = AW'(0);
                state_nxt = ST_PR_RD;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UP: begin
        mem_we      = wr_pend_r;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = ptr_r + AW'(1);
        if (ptr_r == ridx_r) begin
          state_nxt = ST_UP_FIN;
        end else begin
          ptr_nxt = ptr_r - AW'(1);
        end
      end
      ST_UP_FIN: begin
        mem_we    = 1'b1;
        state_nxt = ST_INS;
      end
      ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = ridx_r;
        mem_wdata = elem_r;
        count_nxt = count_r + CW'(1);
        state_nxt = ST_IDLE;
      end
      ST_DN: begin
        mem_we      = wr_pend_r;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = ptr_r - AW'(1);
        if (CW'(ptr_r) == count_m1) begin
          state_nxt = ST_DN_FIN;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_DN_FIN: begin
        mem_we    = wr_pend_r;
        count_nxt = count_m1;
        state_nxt = ST_IDLE;
      end
      ST_GET_RD: begin
        mem_raddr = ridx_r;
        state_nxt = ST_GET_OUT;
      end
      ST_GET_OUT: begin
        mem_raddr = ridx_r;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_value_nxt  = rd_data_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_PR_RD: begin
        state_nxt = ST_PR_OUT;
      end
      ST_PR_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_value_nxt  = rd_data_r;
          out_last_nxt   = pr_last;
          if (pr_last) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            mem_raddr = ptr_r + AW'(1);
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_value_nxt  = 8'd0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      wr_pend_r   <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    wr_addr_r    <= wr_addr_nxt;
    ridx_r       <= ridx_nxt;
    elem_r       <= elem_nxt;
    resp_r       <= resp_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != ST_IDLE)
    else $error("accepted request did not start the sequencer");

  a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STS_OK |-> out_value_r == 8'd0 && out_last_r)
    else $error("error result carries data or is not last");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> $past(state_r) == ST_INS || $past(state_r) == ST_DN_FIN)
    else $error("element count changed outside add or delete completion");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE || state_r == ST_RESP || state_r == ST_PR_OUT |-> !mem_we)
    else $error("memory written outside an add or delete");

endmodule
